### src/wrgs_pkg.sv
// weighted rgb gradient step: shared widths, codes and constants
// no dependencies; used by the channel interfaces, the top level and the testbench
`timescale 1ns / 1ps

package wrgs_pkg;

   // payload widths
   localparam int CHAN_W      = 8;
   localparam int INDEX_W     = 8;
   localparam int COLOR_W     = 24;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 24;
   localparam int COUNT_W     = 8;
   localparam int WEIGHT_W    = 16;

   // largest step count that still gives colours
   localparam int MAX_STEPS = 150;

   // default fraction bits of the fixed point datapath
   localparam int FRAC_BITS_DEFAULT = 16;

   // weight thresholds in unsigned q0.16
   localparam logic [WEIGHT_W-1:0] W_EIGHTH  = 16'd8192;
   localparam logic [WEIGHT_W-1:0] W_QUARTER = 16'd16384;

   // register reset values
   localparam logic [COLOR_W-1:0]  START_COLOR_RST = 24'hFF0000;
   localparam logic [COLOR_W-1:0]  END_COLOR_RST   = 24'h00FFFF;
   localparam logic [COUNT_W-1:0]  STEP_COUNT_RST  = 8'd20;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RST      = 16'h8000;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_WEIGHT_LO = 2'd1,
      STATUS_BAD_INDEX = 2'd2
   } status_type;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_COLOR = 8'd0,
      CSR_END_COLOR   = 8'd1,
      CSR_STEP_COUNT  = 8'd2,
      CSR_WEIGHT      = 8'd3
   } csr_index_type;

endpackage

### src/wrgs_if.sv
// weighted rgb gradient step: request, response and register write channels
// depends on wrgs_pkg
`timescale 1ns / 1ps

interface wrgs_req_if;
   import wrgs_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] step_index;

   modport source (output valid, output step_index, input ready);
   modport sink   (input valid, input step_index, output ready);
endinterface

interface wrgs_rsp_if;
   import wrgs_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   status_type        status;

   modport source (output valid, output red, output green, output blue, output status,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input status,
                   output ready);
endinterface

interface wrgs_csr_if;
   import wrgs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### src/weighted_rgb_gradient_step.sv
// weighted rgb gradient step: top level, register file and full datapath pipeline
// depends on wrgs_pkg and the channels in wrgs_if.sv
//
//  channel   direction  beat carries                    handshake
//  req_bus   in         step_index                      valid / ready
//  rsp_bus   out        red, green, blue, status        valid / ready
//  csr_bus   in         index, data (register write)    valid / ready (always ready)
//
// one beat is taken every cycle while the pipeline advances; a beat passes the
// position divider (an entry register, then four quotient bits per stage) and
// six arithmetic stages on its way to rsp valid.
// the whole pipeline advances together whenever the output register is empty
// or being emptied; a stall freezes every stage and req ready drops with it.
// synchronous reset clears the valid bits and loads the register reset values.
`timescale 1ns / 1ps

module weighted_rgb_gradient_step #(
   parameter int FRAC_BITS = wrgs_pkg::FRAC_BITS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   wrgs_req_if.sink       req_bus,
   wrgs_rsp_if.source     rsp_bus,
   wrgs_csr_if.sink       csr_bus
);
   import wrgs_pkg::*;

   localparam int F          = FRAC_BITS;
   localparam int CW         = F + 3;          // signed q2.f coefficients and t
   localparam int PW         = CW + F + 1;     // coefficient times power of x
   localparam int CPW        = CW + 9;         // channel difference times t
   localparam int DIV_STEP   = 4;
   localparam int DIV_STAGES = (F + DIV_STEP - 1) / DIV_STEP;
   localparam int REM_W      = COUNT_W + 1;

   localparam logic [CW-1:0]  ONE_C   = CW'(1) << F;
   localparam logic [CPW-1:0] ROUND_C = (CPW'(1) << F) - CPW'(1);

   // configuration registers
   logic [COLOR_W-1:0]  start_color_ff;
   logic [COLOR_W-1:0]  end_color_ff;
   logic [COUNT_W-1:0]  step_count_ff;
   logic [WEIGHT_W-1:0] weight_ff;

   // values derived from configuration, refreshed every cycle
   logic [F-1:0]        m;
   logic [CW-1:0]       m_ext;
   logic signed [CW-1:0] coef_a_in, coef_b_in;
   logic signed [CW-1:0] coef_a_ff, coef_b_ff;
   logic [REM_W-1:0]    divisor_ff;
   logic                cubic_ff;

   // pipeline control
   logic                adv;
   logic [DIV_STAGES:0] div_v_ff;
   logic                p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff, p5_v_ff, rsp_v_ff;

   // divider stages, index 0 is the entry register
   logic [REM_W-1:0]    div_r_ff  [DIV_STAGES+1];
   logic [F-1:0]        div_q_ff  [DIV_STAGES+1];
   status_type          div_st_ff [DIV_STAGES+1];
   logic [REM_W-1:0]    div_r_in  [DIV_STAGES+1];
   logic [F-1:0]        div_q_in  [DIV_STAGES+1];
   status_type          entry_st;

   // arithmetic stages
   logic [F-1:0]        x_ff, x2_ff, x2_in, x3;
   logic [F-1:0]        p_ff, q_ff;
   logic signed [PW-1:0] pa_ff, pb_ff;
   logic [PW:0]         t_sum;
   logic signed [CW-1:0] t_ff;
   logic signed [CPW-1:0] prod_ff [3];
   logic signed [CPW-1:0] prod_in [3];
   logic [CHAN_W-1:0]   chan_in [3];
   logic [CHAN_W-1:0]   rsp_chan_ff [3];
   status_type          p1_st_ff, p2_st_ff, p3_st_ff, p4_st_ff, p5_st_ff, rsp_st_ff;

   // register writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_color_ff <= START_COLOR_RST;
         end_color_ff   <= END_COLOR_RST;
         step_count_ff  <= STEP_COUNT_RST;
         weight_ff      <= WEIGHT_RST;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_START_COLOR: start_color_ff <= csr_bus.data[COLOR_W-1:0];
            CSR_END_COLOR:   end_color_ff   <= csr_bus.data[COLOR_W-1:0];
            CSR_STEP_COUNT:  step_count_ff  <= csr_bus.data[COUNT_W-1:0];
            CSR_WEIGHT:      weight_ff      <= csr_bus.data[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // weight rescaled to f fraction bits
   if (F >= WEIGHT_W) begin : g_m_up
      assign m = F'(weight_ff) << (F - WEIGHT_W);
   end else begin : g_m_down
      assign m = F'(weight_ff >> (WEIGHT_W - F));
   end

   // easing coefficients: quadratic from a quarter upwards, cubic below
   always_comb begin
      m_ext = CW'(m);
      if (weight_ff >= W_QUARTER) begin
         coef_a_in = (ONE_C << 1) - (m_ext << 2);
         coef_b_in = (m_ext << 2) - ONE_C;
      end else begin
         coef_a_in = (ONE_C << 1) - (m_ext << 3);
         coef_b_in = (m_ext << 3) - ONE_C;
      end
   end

   always_ff @(posedge clock) begin
      coef_a_ff  <= coef_a_in;
      coef_b_ff  <= coef_b_in;
      divisor_ff <= REM_W'(step_count_ff) + REM_W'(1);
      cubic_ff   <= (weight_ff < W_QUARTER);
   end

   // whole pipeline moves when the output register can take a beat
   assign adv           = !rsp_v_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // status of an incoming beat, weight check first
   always_comb begin
      if (weight_ff < W_EIGHTH) begin
         entry_st = STATUS_WEIGHT_LO;
      end else if (REM_W'(step_count_ff) > REM_W'(MAX_STEPS) ||
                   req_bus.step_index >= step_count_ff) begin
         entry_st = STATUS_BAD_INDEX;
      end else begin
         entry_st = STATUS_OK;
      end
   end

   // restoring division of (index+1)<<f by n+1, four quotient bits a stage
   always_comb begin
      logic [REM_W-1:0] r;
      logic [REM_W:0]   r2;
      logic [F-1:0]     q;
      div_r_in[0] = REM_W'(req_bus.step_index) + REM_W'(1);
      div_q_in[0] = '0;
      for (int g = 0; g < DIV_STAGES; g++) begin
         r = div_r_ff[g];
         q = div_q_ff[g];
         for (int k = 0; k < DIV_STEP; k++) begin
            if (g * DIV_STEP + k < F) begin
               r2 = {r, 1'b0};
               if (r2 >= {1'b0, divisor_ff}) begin
                  r = REM_W'(r2 - {1'b0, divisor_ff});
                  q = {q[F-2:0], 1'b1};
               end else begin
                  r = r2[REM_W-1:0];
                  q = {q[F-2:0], 1'b0};
               end
            end
         end
         div_r_in[g+1] = r;
         div_q_in[g+1] = q;
      end
   end

   // x squared from the divider output, x cubed from the first arithmetic stage
   always_comb begin
      logic [2*F-1:0] xx;
      logic [2*F-1:0] x3_full;
      xx      = (2*F)'(div_q_ff[DIV_STAGES]) * (2*F)'(div_q_ff[DIV_STAGES]);
      x2_in   = xx[2*F-1:F];
      x3_full = (2*F)'(x2_ff) * (2*F)'(x_ff);
      x3      = x3_full[2*F-1:F];
   end

   // t, floored by taking the upper bits of the signed sum
   assign t_sum = {pa_ff[PW-1], pa_ff} + {pb_ff[PW-1], pb_ff};

   // channel difference times t
   always_comb begin
      logic signed [8:0] d;
      for (int c = 0; c < 3; c++) begin
         d = $signed({1'b0, end_color_ff[c*CHAN_W +: CHAN_W]}) -
             $signed({1'b0, start_color_ff[c*CHAN_W +: CHAN_W]});
         prod_in[c] = CPW'(d) * CPW'(t_ff);
      end
   end

   // delta rounded toward zero, added to the start channel with wrap
   always_comb begin
      logic [CPW-1:0] corr;
      for (int c = 0; c < 3; c++) begin
         corr = prod_ff[c] + (prod_ff[c][CPW-1] ? ROUND_C : '0);
         if (p5_st_ff == STATUS_OK) begin
            chan_in[c] = start_color_ff[c*CHAN_W +: CHAN_W] + corr[F +: CHAN_W];
         end else begin
            chan_in[c] = '0;
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         div_v_ff <= '0;
         p1_v_ff  <= 1'b0;
         p2_v_ff  <= 1'b0;
         p3_v_ff  <= 1'b0;
         p4_v_ff  <= 1'b0;
         p5_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         div_v_ff <= {div_v_ff[DIV_STAGES-1:0], req_bus.valid};
         p1_v_ff  <= div_v_ff[DIV_STAGES];
         p2_v_ff  <= p1_v_ff;
         p3_v_ff  <= p2_v_ff;
         p4_v_ff  <= p3_v_ff;
         p5_v_ff  <= p4_v_ff;
         rsp_v_ff <= p5_v_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         div_r_ff[0]  <= div_r_in[0];
         div_q_ff[0]  <= div_q_in[0];
         div_st_ff[0] <= entry_st;
         for (int g = 1; g <= DIV_STAGES; g++) begin
            div_r_ff[g]  <= div_r_in[g];
            div_q_ff[g]  <= div_q_in[g];
            div_st_ff[g] <= div_st_ff[g-1];
         end
         // x and x squared
         x_ff     <= div_q_ff[DIV_STAGES];
         x2_ff    <= x2_in;
         p1_st_ff <= div_st_ff[DIV_STAGES];
         // powers used by the chosen easing form
         p_ff     <= cubic_ff ? x3 : x2_ff;
         q_ff     <= cubic_ff ? x2_ff : x_ff;
         p2_st_ff <= p1_st_ff;
         // coefficient products
         pa_ff    <= PW'(coef_a_ff) * PW'($signed({1'b0, p_ff}));
         pb_ff    <= PW'(coef_b_ff) * PW'($signed({1'b0, q_ff}));
         p3_st_ff <= p2_st_ff;
         // eased position
         t_ff     <= t_sum[F +: CW];
         p4_st_ff <= p3_st_ff;
         // channel products
         for (int c = 0; c < 3; c++) begin
            prod_ff[c] <= prod_in[c];
         end
         p5_st_ff <= p4_st_ff;
         // output register
         for (int c = 0; c < 3; c++) begin
            rsp_chan_ff[c] <= chan_in[c];
         end
         rsp_st_ff <= p5_st_ff;
      end
   end

   assign rsp_bus.valid  = rsp_v_ff;
   assign rsp_bus.red    = rsp_chan_ff[0];
   assign rsp_bus.green  = rsp_chan_ff[1];
   assign rsp_bus.blue   = rsp_chan_ff[2];
   assign rsp_bus.status = rsp_st_ff;

   // an error beat carries black
   a_error_black: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_st_ff != STATUS_OK |-> rsp_chan_ff[0] == '0 &&
         rsp_chan_ff[1] == '0 && rsp_chan_ff[2] == '0)
      else $error("error beat with non-zero colour");

   // a stall freezes the divider, first stage, fifth stage and output valid bits
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(div_v_ff) && $stable(p1_v_ff) && $stable(p5_v_ff) &&
         $stable(rsp_v_ff))
      else $error("stage valid bits moved during a stall");

   // the partial remainder of a good beat stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      div_v_ff[DIV_STAGES] && div_st_ff[DIV_STAGES] == STATUS_OK |->
         div_r_ff[DIV_STAGES] < divisor_ff)
      else $error("divider remainder out of range");

   // a good beat never leaves with a weight below one eighth
   a_ok_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_st_ff == STATUS_OK |-> weight_ff >= W_EIGHTH)
      else $error("good beat with weight below one eighth");

endmodule

### test/weighted_rgb_gradient_step_tb.sv
// weighted rgb gradient step: self-checking testbench with queue-fed driver and monitor
// depends on wrgs_pkg, the channels in wrgs_if.sv and the weighted_rgb_gradient_step top level
`timescale 1ns / 1ps

module weighted_rgb_gradient_step_tb;
   import wrgs_pkg::*;

   localparam int FRAC = FRAC_BITS_DEFAULT;
   localparam longint ONE_Q = longint'(1) <<< FRAC;
   localparam int SETTLE_CYCLES = 14;
   localparam int RANDOM_PHASES = 20;
   localparam int STEPS_PER_PHASE = 35;
   localparam int QUIET_PHASES = 3;

   // register indexes the block does not decode
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST  = 8'd255;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      status_type        status;
   } colour_beat_type;

   logic clock;
   logic reset;

   wrgs_req_if req_bus ();
   wrgs_rsp_if rsp_bus ();
   wrgs_csr_if csr_bus ();

   weighted_rgb_gradient_step uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // register mirror, updated on accepted register writes
   logic [COLOR_W-1:0]  cfg_start;
   logic [COLOR_W-1:0]  cfg_end;
   logic [COUNT_W-1:0]  cfg_count;
   logic [WEIGHT_W-1:0] cfg_weight;

   logic [INDEX_W-1:0] step_queue[$];
   colour_beat_type    colour_due[$];
   colour_beat_type    colour_seen;
   bit                 idle_on;
   int                 req_gap;
   int                 rsp_stall;
   int                 faults;

   // one channel of the blend: delta truncated toward zero, sum wrapped to 8 bits
   function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] from_c,
                                                    input logic [CHAN_W-1:0] to_c,
                                                    input longint t);
      longint d;
      longint delta;
      d = longint'({56'd0, to_c}) - longint'({56'd0, from_c});
      delta = (d * t) / ONE_Q;
      return from_c + delta[CHAN_W-1:0];
   endfunction

   // expected colour for one step index under the mirrored registers
   function automatic colour_beat_type gradient_colour(input logic [INDEX_W-1:0] idx);
      colour_beat_type r;
      longint m;
      longint x;
      longint x2;
      longint x3;
      longint t;
      longint w64;
      r = '0;
      r.status = STATUS_OK;
      if (cfg_weight < W_EIGHTH) begin
         r.status = STATUS_WEIGHT_LO;
         return r;
      end
      if (int'(cfg_count) > MAX_STEPS || idx >= cfg_count) begin
         r.status = STATUS_BAD_INDEX;
         return r;
      end
      w64 = {48'd0, cfg_weight};
      if (FRAC >= 16) m = w64 <<< (FRAC - 16);
      else m = w64 >>> (16 - FRAC);
      x = (longint'({56'd0, idx}) + 1) * ONE_Q / (longint'({56'd0, cfg_count}) + 1);
      x2 = (x * x) >>> FRAC;
      // quadratic easing from a quarter upwards, cubic between an eighth and a quarter
      if (cfg_weight >= W_QUARTER) begin
         t = ((2 * ONE_Q - 4 * m) * x2 + (4 * m - ONE_Q) * x) >>> FRAC;
      end else begin
         x3 = (x2 * x) >>> FRAC;
         t = ((2 * ONE_Q - 8 * m) * x3 + (8 * m - ONE_Q) * x2) >>> FRAC;
      end
      r.red   = mix_channel(cfg_start[7:0],   cfg_end[7:0],   t);
      r.green = mix_channel(cfg_start[15:8],  cfg_end[15:8],  t);
      r.blue  = mix_channel(cfg_start[23:16], cfg_end[23:16], t);
      return r;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         faults++;
      end
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // request driver: register mirror, prediction on accepted beats, idle bursts
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.step_index <= '0;
         req_gap = 0;
         cfg_start  <= START_COLOR_RST;
         cfg_end    <= END_COLOR_RST;
         cfg_count  <= STEP_COUNT_RST;
         cfg_weight <= WEIGHT_RST;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_START_COLOR: cfg_start  <= csr_bus.data;
               CSR_END_COLOR:   cfg_end    <= csr_bus.data;
               CSR_STEP_COUNT:  cfg_count  <= csr_bus.data[COUNT_W-1:0];
               CSR_WEIGHT:      cfg_weight <= csr_bus.data[WEIGHT_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            colour_due.push_back(gradient_colour(req_bus.step_index));
            void'(step_queue.pop_front());
         end
         if (req_bus.valid && !req_bus.ready) begin
            // hold the beat until taken
         end else if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            req_gap = $urandom_range(0, 16);
            req_bus.valid <= 1'b0;
         end else if (step_queue.size() != 0) begin
            req_bus.valid      <= 1'b1;
            req_bus.step_index <= step_queue[0];
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response monitor: compare against the oldest expected colour, random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (colour_due.size() == 0) begin
               $error("unexpected beat: red %0d green %0d blue %0d status %0d",
                      rsp_bus.red, rsp_bus.green, rsp_bus.blue, rsp_bus.status);
               faults++;
            end else begin
               colour_seen = colour_due.pop_front();
               check_field("red",    int'(colour_seen.red),    int'(rsp_bus.red));
               check_field("green",  int'(colour_seen.green),  int'(rsp_bus.green));
               check_field("blue",   int'(colour_seen.blue),   int'(rsp_bus.blue));
               check_field("status", int'(colour_seen.status), int'(rsp_bus.status));
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 11) == 0) begin
            rsp_stall = $urandom_range(0, 16);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic apply_setting(input logic [COLOR_W-1:0] from_c, input logic [COLOR_W-1:0] to_c,
                                input logic [COUNT_W-1:0] count, input logic [WEIGHT_W-1:0] w);
      write_register(CSR_START_COLOR, from_c);
      write_register(CSR_END_COLOR, to_c);
      write_register(CSR_STEP_COUNT, {16'd0, count});
      write_register(CSR_WEIGHT, {8'd0, w});
   endtask

   // wait until every queued step has come back, then let the pipeline settle
   task automatic drain();
      while (step_queue.size() != 0 || colour_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // run limit
   initial begin
      #(5_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   // stimulus
   initial begin
      logic [COLOR_W-1:0]  from_c;
      logic [COLOR_W-1:0]  to_c;
      logic [COUNT_W-1:0]  count;
      logic [WEIGHT_W-1:0] w;
      int                  phase;
      int                  k;

      reset = 1'b1;
      faults = 0;
      idle_on = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.step_index = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset register values: first, last and first invalid index
      step_queue.push_back(8'd0);
      step_queue.push_back(8'd19);
      step_queue.push_back(8'd20);
      drain();

      // weight below an eighth wins over a bad index
      apply_setting(24'h123456, 24'h654321, 8'd10, 16'd0);
      step_queue.push_back(8'd0);
      step_queue.push_back(8'd255);
      drain();
      apply_setting(24'h123456, 24'h654321, 8'd10, 16'd8191);
      step_queue.push_back(8'd3);
      drain();

      // cubic easing at both edges of its weight range, full range of steps
      apply_setting(24'h000000, 24'hFFFFFF, 8'd150, 16'd8192);
      step_queue.push_back(8'd0);
      step_queue.push_back(8'd74);
      step_queue.push_back(8'd149);
      step_queue.push_back(8'd150);
      drain();
      apply_setting(24'hFFFFFF, 24'h000000, 8'd150, 16'd16383);
      step_queue.push_back(8'd0);
      step_queue.push_back(8'd149);
      drain();

      // quadratic easing at both ends of the weight range
      apply_setting(24'hFFFFFF, 24'h000000, 8'd1, 16'd16384);
      step_queue.push_back(8'd0);
      step_queue.push_back(8'd1);
      drain();
      apply_setting(24'h00FF80, 24'hFF0017, 8'd1, 16'd65535);
      step_queue.push_back(8'd0);
      drain();
      write_register(CSR_STEP_COUNT, 24'd150);
      step_queue.push_back(8'd149);
      drain();

      // zero steps and step counts beyond the maximum
      write_register(CSR_STEP_COUNT, 24'd0);
      step_queue.push_back(8'd0);
      drain();
      write_register(CSR_STEP_COUNT, 24'd151);
      step_queue.push_back(8'd0);
      drain();
      write_register(CSR_STEP_COUNT, 24'd255);
      step_queue.push_back(8'd254);
      step_queue.push_back(8'd255);
      drain();

      // writes to undecoded indexes leave the registers alone
      write_register(CSR_STEP_COUNT, 24'd5);
      write_register(CSR_SPARE_FIRST, 24'hFFFFFF);
      write_register(CSR_SPARE_LAST, 24'h000000);
      step_queue.push_back(8'd1);
      drain();

      // random settings, mostly well-formed with valid indexes
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_on = (phase < RANDOM_PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0: w = WEIGHT_W'($urandom_range(0, W_EIGHTH - 1));
            1, 2: w = WEIGHT_W'($urandom_range(W_EIGHTH, W_QUARTER - 1));
            3: w = ($urandom_range(0, 1) != 0) ? W_EIGHTH : 16'hFFFF;
            default: w = WEIGHT_W'($urandom_range(W_QUARTER, 16'hFFFF));
         endcase
         case ($urandom_range(0, 9))
            0: count = COUNT_W'($urandom_range(0, 255));
            1: count = ($urandom_range(0, 1) != 0) ? 8'd1 : COUNT_W'(MAX_STEPS);
            2, 3, 4: count = COUNT_W'($urandom_range(1, 20));
            default: count = COUNT_W'($urandom_range(1, MAX_STEPS));
         endcase
         from_c = COLOR_W'($urandom());
         to_c = COLOR_W'($urandom());
         if ($urandom_range(0, 7) == 0) from_c = '0;
         if ($urandom_range(0, 7) == 0) to_c = '1;
         apply_setting(from_c, to_c, count, w);
         if ($urandom_range(0, 4) == 0)
            write_register(CSR_INDEX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                           CSR_DATA_W'($urandom()));
         for (k = 0; k < STEPS_PER_PHASE; k++) begin
            if (count >= 1 && int'(count) <= MAX_STEPS && $urandom_range(0, 9) != 0)
               step_queue.push_back(INDEX_W'($urandom_range(0, count - 1)));
            else
               step_queue.push_back(INDEX_W'($urandom_range(0, 255)));
         end
         drain();
      end

      if (faults == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### sim.f
src/wrgs_pkg.sv
src/wrgs_if.sv
src/weighted_rgb_gradient_step.sv
test/weighted_rgb_gradient_step_tb.sv
